// ----- rtl/min_heap_insert_delete_value_unit_macros.svh -----
// Assertion macros shared by the heap unit checker.
`ifndef MIN_HEAP_INSERT_DELETE_VALUE_UNIT_MACROS_SVH
`define MIN_HEAP_INSERT_DELETE_VALUE_UNIT_MACROS_SVH

// Clocked property with reset disable; clk and rst_n come from the scope of use.
`define MHID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form built on the macro above.
`define MHID_ASSERT_IMP(label, ante, cons, msg) \
    `MHID_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/mhid_pkg.sv -----
// Shared types and constants of the min-heap insert/delete unit.
package mhid_pkg;

    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 11;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 1024;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UP,
        ST_UPCMP,
        ST_DN,
        ST_DNL,
        ST_DNR,
        ST_FIN
    } state_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// ----- rtl/mhid_mem.sv -----
// Heap key store: one write port, one read port with registered read data.
module mhid_mem
    import mhid_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [KEY_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic signed [KEY_W-1:0] rdata
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mhid_ctrl.sv -----
// Sequencer: linear search, sift-up and sift-down over the key store.
module mhid_ctrl
    import mhid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    kind,
    input  logic signed [KEY_W-1:0] key,
    output res_t                    res,
    input  logic                    res_ready,
    output logic                    mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic signed [KEY_W-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic signed [KEY_W-1:0] mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] cur_reg, cur_next;
    logic signed [KEY_W-1:0] lval_reg, lval_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           issue_reg, issue_next;
    logic [AW-1:0]           chk_reg, chk_next;
    logic                    pend_reg, pend_next;
    logic                    moved_reg, moved_next;
    logic                    del_reg, del_next;
    status_t                 status_reg, status_next;

    logic [CW-1:0]           last_idx;
    logic                    scan_more;
    logic                    hit;
    logic                    hit_last;
    logic                    full;
    logic [AW-1:0]           par;
    logic                    up_less;
    logic                    go_down;
    logic [XW-1:0]           lidx, ridx;
    logic                    has_l, has_r;
    logic signed [KEY_W-1:0] cand_l, bv1, bv;
    logic                    l_smaller, r_smaller, moves;
    logic [XW-1:0]           best_idx;

    // shared decode
    always_comb
    begin
        last_idx  = count_reg - CW'(1);
        scan_more = issue_reg < count_reg;
        hit       = pend_reg && (mem_rdata == key_reg);
        hit_last  = CW'(chk_reg) == last_idx;
        full      = count_reg >= CW'(CAPACITY);
        par       = (pos_reg - AW'(1)) >> 1;
        up_less   = cur_reg < mem_rdata;
        go_down   = del_reg && !moved_reg;
        lidx      = XW'({pos_reg, 1'b1});
        ridx      = lidx + XW'(1);
        has_l     = lidx < XW'(count_reg);
        has_r     = ridx < XW'(count_reg);
        cand_l    = (state_reg == ST_DNL) ? mem_rdata : lval_reg;
        l_smaller = cand_l < cur_reg;
        bv1       = l_smaller ? cand_l : cur_reg;
        r_smaller = (state_reg == ST_DNR) && (mem_rdata < bv1);
        moves     = l_smaller || r_smaller;
        best_idx  = r_smaller ? ridx : lidx;
        bv        = r_smaller ? mem_rdata : bv1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        state_next = full ? ST_FIN : ST_UP;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_FIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = hit_last ? ST_FIN : ST_LAST;
                end
                else if (!scan_more)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_LAST:  state_next = ST_UP;
            ST_UP:
            begin
                if (pos_reg != '0)
                begin
                    state_next = ST_UPCMP;
                end
                else
                begin
                    state_next = go_down ? ST_DN : ST_FIN;
                end
            end
            ST_UPCMP:
            begin
                if (up_less)
                begin
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = go_down ? ST_DN : ST_FIN;
                end
            end
            ST_DN:    state_next = has_l ? ST_DNL : ST_FIN;
            ST_DNL:
            begin
                if (has_r)
                begin
                    state_next = ST_DNR;
                end
                else
                begin
                    state_next = moves ? ST_DN : ST_FIN;
                end
            end
            ST_DNR:   state_next = moves ? ST_DN : ST_FIN;
            ST_FIN:   state_next = res_ready ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: memory controls, handshake, result
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = cur_reg;
        mem_re    = 1'b0;
        mem_raddr = AW'(issue_reg);
        case (state_reg)
            ST_SCAN:
            begin
                if (hit)
                begin
                    mem_re    = !hit_last;
                    mem_raddr = AW'(last_idx);
                end
                else
                begin
                    mem_re = scan_more;
                end
            end
            ST_UP:
            begin
                if (pos_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = par;
                end
                else
                begin
                    mem_we = !go_down;
                end
            end
            ST_UPCMP:
            begin
                if (up_less)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                end
                else
                begin
                    mem_we = !go_down;
                end
            end
            ST_DN:
            begin
                if (has_l)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(lidx);
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            ST_DNL:
            begin
                if (has_r)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ridx);
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = bv;
                end
            end
            ST_DNR:
            begin
                mem_we    = 1'b1;
                mem_wdata = bv;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        in_stall   = state_reg != ST_IDLE;
        res.valid  = state_reg == ST_FIN;
        res.status = status_reg;
        res.count  = COUNT_W'(count_reg);
    end

    // datapath next values
    always_comb
    begin
        count_next  = count_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        lval_next   = lval_reg;
        pos_next    = pos_reg;
        issue_next  = issue_reg;
        chk_next    = chk_reg;
        pend_next   = pend_reg;
        moved_next  = moved_reg;
        del_next    = del_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = key;
                    status_next = STATUS_DONE;
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    if (kind == KIND_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            cur_next   = key;
                            moved_next = 1'b0;
                            del_next   = 1'b0;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    count_next = last_idx;
                    pos_next   = chk_reg;
                end
                else if (!scan_more)
                begin
                    status_next = STATUS_NOT_FOUND;
                end
                else
                begin
                    chk_next   = AW'(issue_reg);
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
            end
            ST_LAST:
            begin
                cur_next   = mem_rdata;
                moved_next = 1'b0;
                del_next   = 1'b1;
            end
            ST_UPCMP:
            begin
                if (up_less)
                begin
                    pos_next   = par;
                    moved_next = 1'b1;
                end
            end
            ST_DNL:
            begin
                lval_next = mem_rdata;
                if (!has_r && moves)
                begin
                    pos_next = AW'(best_idx);
                end
            end
            ST_DNR:
            begin
                if (moves)
                begin
                    pos_next = AW'(best_idx);
                end
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        lval_reg   <= lval_next;
        pos_reg    <= pos_next;
        issue_reg  <= issue_next;
        chk_reg    <= chk_next;
        pend_reg   <= pend_next;
        moved_reg  <= moved_next;
        del_reg    <= del_next;
        status_reg <= status_next;
    end

endmodule

// ----- rtl/min_heap_insert_delete_value_unit.sv -----
// Top level of the min-heap insert/delete-by-value unit.
// Binary min-heap of signed 32-bit keys held in one single-port-read,
// single-port-write RAM of CAPACITY entries (root at slot 0, children of
// slot i at 2i+1 and 2i+2). Each input item is an insert (kind 0) or a
// delete of the first key equal to key in slot order (kind 1); each item
// yields exactly one result item with a status (done, not found, full) and
// the element count after the operation, masked to 11 bits. One item is
// worked at a time. An insert sifts the new key up; a delete scans one
// slot per cycle for the search, fetches the last element, then sifts it
// up or, if it did not move, down. The next input item is taken as soon
// as the sequencer returns to idle, even while the previous result still
// waits in the output register. The key RAM needs no clearing after reset:
// only slots below the count are ever read.
module min_heap_insert_delete_value_unit
    import mhid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic signed [KEY_W-1:0]   key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [STATUS_W-1:0]       status,
    output logic [COUNT_W-1:0]        count
);

    localparam int AW = $clog2(CAPACITY);

    res_t                    res;
    logic                    res_ready;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic signed [KEY_W-1:0] mem_wdata, mem_rdata;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_out_reg;
    logic [COUNT_W-1:0]      cnt_out_reg;

    mhid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .key       (key),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    mhid_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: loads when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            status_out_reg <= res.status;
            cnt_out_reg    <= res.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign count     = cnt_out_reg;

endmodule

// ----- rtl/mhid_checker.sv -----
// Port-level checker for the heap unit, bound to the top level.
`include "min_heap_insert_delete_value_unit_macros.svh"

module mhid_checker
    import mhid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [STATUS_W-1:0]     status,
    input logic [COUNT_W-1:0]      count
);

    logic [COUNT_W-1:0] prev_cnt_reg;
    logic               out_take;
    logic               is_done;

    assign out_take = out_valid && !out_stall;
    assign is_done  = status == STATUS_DONE;

    // count carried by the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cnt_reg <= '0;
        end
        else if (out_take)
        begin
            prev_cnt_reg <= count;
        end
    end

    `MHID_ASSERT_IMP(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(status) && $stable(count)), "stalled result changed")
    `MHID_ASSERT_IMP(a_reject_keeps, out_valid && !is_done, count == prev_cnt_reg, "rejected item changed count")
    `MHID_ASSERT_IMP(a_full_at_cap, out_valid && status == STATUS_FULL, count == COUNT_W'(CAPACITY), "full reported below capacity")
    `MHID_ASSERT_IMP(a_done_step, out_valid && is_done, (count == prev_cnt_reg + COUNT_W'(1)) || (count == prev_cnt_reg - COUNT_W'(1)), "count moved by other than one")

endmodule

bind min_heap_insert_delete_value_unit mhid_checker #(.CAPACITY(CAPACITY)) u_mhid_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the min-heap insert/delete-by-value unit.
module testbench;
    import mhid_pkg::*;

    // Fixed watchdog: far above the slowest legal run of this stimulus.
    localparam longint WATCHDOG_TIME = 64'd18_000_000;
    localparam int     IDLE_PCT      = 36;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SIZE_CEILING  = 96;   // random traffic keeps scans short
    localparam int     TAIL_CYCLES   = 64;

    typedef struct {
        status_t            status;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic                    kind      = KIND_INSERT;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;

    // Predictor state: its own copy of the heap array and element count.
    logic signed [KEY_W-1:0] heap_keys [CAPACITY_DEF];
    int                      heap_size = 0;

    // Results still owed by the block, oldest first.
    heap_result_t            expected_results [$];

    int                      err_count = 0;
    bit                      quiet     = 1'b0;  // disables random idling on both sides
    int                      hold_left = 0;     // receiver hold-off, counted down per cycle

    min_heap_insert_delete_value_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_TIME);
        $display("TEST FAILED");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Move the key at pos toward the root while strictly below its parent.
    function automatic void heap_climb(input int pos);
        logic signed [KEY_W-1:0] tmp;
        int                      up;
        while (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2])
        begin
            up             = (pos - 1) / 2;
            tmp            = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up]  = tmp;
            pos            = up;
        end
    endfunction

    // Push the key at pos down; ties keep the node, child ties keep the left.
    function automatic void heap_sink(input int pos);
        logic signed [KEY_W-1:0] tmp;
        int                      best;
        bit                      settled;
        settled = 1'b0;
        while (!settled && pos < heap_size)
        begin
            best = pos;
            if (2 * pos + 1 < heap_size && heap_keys[2 * pos + 1] < heap_keys[best])
                best = 2 * pos + 1;
            if (2 * pos + 2 < heap_size && heap_keys[2 * pos + 2] < heap_keys[best])
                best = 2 * pos + 2;
            if (best == pos)
                settled = 1'b1;
            else
            begin
                tmp             = heap_keys[pos];
                heap_keys[pos]  = heap_keys[best];
                heap_keys[best] = tmp;
                pos             = best;
            end
        end
    endfunction

    // Apply one operation to the predictor and return the status it yields.
    function automatic status_t predict_heap_op(input logic op,
                                                input logic signed [KEY_W-1:0] k);
        int pos;
        if (op == KIND_INSERT)
        begin
            if (heap_size >= CAPACITY_DEF)
                return STATUS_FULL;
            heap_keys[heap_size] = k;
            heap_size++;
            heap_climb(heap_size - 1);
            return STATUS_DONE;
        end
        // Linear search in slot order: the first equal key is removed.
        pos = 0;
        while (pos < heap_size && heap_keys[pos] != k)
            pos++;
        if (pos >= heap_size)
            return STATUS_NOT_FOUND;
        heap_size--;
        heap_keys[pos] = heap_keys[heap_size];
        // Removing the last slot needs no repair.
        if (pos < heap_size)
        begin
            heap_climb(pos);
            heap_sink(pos);
        end
        return STATUS_DONE;
    endfunction

    function automatic bit key_present(input logic signed [KEY_W-1:0] k);
        for (int i = 0; i < heap_size; i++)
            if (heap_keys[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    // Insert keys: often a narrow band so duplicates are common.
    function automatic logic signed [KEY_W-1:0] pick_insert_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom_range(16) - 8;
        if (sel < 45)
            return {1'b0, {(KEY_W-1){1'b1}}};
        if (sel < 50)
            return {1'b1, {(KEY_W-1){1'b0}}};
        return $urandom;
    endfunction

    //------------------------------------------------------------------
    // Sender: offers one item and returns at the edge where it is taken.
    // in_valid stays high on return so back-to-back items need no gap.
    //------------------------------------------------------------------
    task automatic offer_item(input logic op, input logic signed [KEY_W-1:0] k);
        heap_result_t res;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        // Taken at this edge: predict now, in acceptance order.
        res.status = predict_heap_op(op, k);
        res.count  = COUNT_W'(heap_size);
        expected_results = {expected_results, res};
    endtask

    // Sender goes quiet until every owed result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Receiver: checks each taken result, then picks the next stall.
    //------------------------------------------------------------------
    initial
    begin
        heap_result_t exp_res;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result item status %0d count %0d",
                                 $time, status, count);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status || count !== exp_res.count)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: mismatch status exp %0d got %0d, count exp %0d got %0d",
                                     $time, exp_res.status, status, exp_res.count, count);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(99) < IDLE_PCT)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Key extremes, duplicates, absent keys, last-slot and root removal.
    task automatic test_directed_edges();
        offer_item(KIND_DELETE, 0);                       // empty heap: not found
        offer_item(KIND_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
        offer_item(KIND_INSERT, {1'b1, {(KEY_W-1){1'b0}}}); // climbs over the max
        offer_item(KIND_INSERT, 0);
        offer_item(KIND_INSERT, -1);
        offer_item(KIND_INSERT, 5);
        offer_item(KIND_INSERT, 5);
        offer_item(KIND_INSERT, 1);
        offer_item(KIND_DELETE, 5);                       // lowest-index duplicate
        offer_item(KIND_DELETE, 12345);                   // absent key
        offer_item(KIND_DELETE, heap_keys[heap_size - 1]);
        offer_item(KIND_DELETE, heap_keys[0]);            // root
        offer_item(KIND_DELETE, {1'b0, {(KEY_W-1){1'b1}}});
        offer_item(KIND_INSERT, 32'sh5555_5555);
        offer_item(KIND_INSERT, 32'shAAAA_AAAA);
        offer_item(KIND_DELETE, 32'shAAAA_AAAA);
        offer_item(KIND_DELETE, 5);
        offer_item(KIND_DELETE, -1);
        offer_item(KIND_DELETE, 0);
        offer_item(KIND_DELETE, 1);
        offer_item(KIND_DELETE, 32'sh5555_5555);          // heap now empty
        offer_item(KIND_DELETE, 32'sh5555_5555);
        wait_drained();
    endtask

    // Phases that grow, shrink or churn the heap; deletes mostly hit.
    task automatic test_random_traffic();
        int                      ins_pct;
        int                      sel;
        logic                    op;
        logic signed [KEY_W-1:0] k;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 3)
                0:       ins_pct = 75;
                1:       ins_pct = 50;
                default: ins_pct = 30;
            endcase
            // One phase runs with no idling on either side.
            quiet = (phase == 4);
            for (int n = 0; n < 40; n++)
            begin
                op = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
                if (heap_size >= SIZE_CEILING)
                    op = KIND_DELETE;
                if (op == KIND_INSERT)
                    k = pick_insert_key();
                else
                begin
                    sel = $urandom_range(99);
                    if (heap_size > 0 && sel < 60)
                        k = heap_keys[$urandom_range(heap_size - 1)];
                    else if (heap_size > 0 && sel < 70)
                        k = heap_keys[0];
                    else if (heap_size > 0 && sel < 78)
                        k = heap_keys[heap_size - 1];
                    else
                        k = pick_insert_key();
                end
                offer_item(op, k);
            end
            quiet = 1'b0;
            if (phase % 4 == 3)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the block fills
    // its output register and then stalls its input.
    task automatic test_output_backpressure();
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 10; n++)
            if (n % 3 == 2 && heap_size > 0)
                offer_item(KIND_DELETE, heap_keys[$urandom_range(heap_size - 1)]);
            else
                offer_item(KIND_INSERT, pick_insert_key());
        wait_drained();
    endtask

    // Grow the heap, scan every slot for absent keys, then drain it.
    task automatic test_deep_scan_and_drain();
        logic signed [KEY_W-1:0] k;
        repeat (24)
            offer_item(KIND_INSERT, pick_insert_key());
        // Absent keys force a scan over every slot.
        for (int n = 0; n < 2; n++)
        begin
            do
                k = $urandom;
            while (key_present(k));
            offer_item(KIND_DELETE, k);
        end
        offer_item(KIND_DELETE, heap_keys[heap_size - 1]);
        offer_item(KIND_DELETE, heap_keys[heap_size / 2]);
        offer_item(KIND_INSERT, pick_insert_key());
        wait_drained();
        // Drain mostly from the root, now and then from anywhere.
        while (heap_size > 0)
            if ($urandom_range(7) == 0)
                offer_item(KIND_DELETE, heap_keys[$urandom_range(heap_size - 1)]);
            else
                offer_item(KIND_DELETE, heap_keys[0]);
        offer_item(KIND_DELETE, pick_insert_key());       // empty again: not found
        wait_drained();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic();
        test_output_backpressure();
        test_deep_scan_and_drain();

        wait_drained();
        // Any stray result in this window is flagged by the receiver.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
